// ===== hw/rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg - performance-state table selector package
// Shared types, action and result codes and fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

   // Fixed field widths
   localparam int ACTION_W = 2;
   localparam int FREQ_W   = 20;
   localparam int WORD_W   = 32;
   localparam int LEVEL_W  = 7;
   localparam int CODE_W   = 4;
   localparam int LIMIT_W  = 5;
   localparam int CSR_W    = 5;
   localparam int CSR_IX_W = 1;

   // Shared divider: 7-bit dividend and divisor, one quotient bit a cycle
   localparam int DIV_W     = 7;
   localparam int DIV_CNT_W = 3;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 7'd100;
   localparam logic [DIV_W-1:0]   FULL_SCALE = 7'd100;

   // Frequencies that are never kept
   localparam logic [FREQ_W-1:0] FREQ_HEX_ONES  = 20'h0FFFF;
   localparam logic [FREQ_W-1:0] FREQ_HEX_NINES = 20'h09999;
   localparam logic [FREQ_W-1:0] FREQ_DEC_NINES = 20'd99999;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REQUEST = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CONFIRM = 2'd3;

   // Result codes
   localparam logic [CODE_W-1:0] RC_KEPT        = 4'd0;
   localparam logic [CODE_W-1:0] RC_REPEAT      = 4'd1;
   localparam logic [CODE_W-1:0] RC_BAD_FREQ    = 4'd2;
   localparam logic [CODE_W-1:0] RC_BAD_LEVEL   = 4'd3;
   localparam logic [CODE_W-1:0] RC_UNAVAILABLE = 4'd4;
   localparam logic [CODE_W-1:0] RC_ALREADY     = 4'd5;
   localparam logic [CODE_W-1:0] RC_WRITE       = 4'd6;
   localparam logic [CODE_W-1:0] RC_OK          = 4'd7;
   localparam logic [CODE_W-1:0] RC_FAILED      = 4'd8;

   // Register indexes
   localparam logic [CSR_IX_W-1:0] CSR_PERF_LIMIT    = 1'd0;
   localparam logic [CSR_IX_W-1:0] CSR_CONTROL_READY = 1'd1;

   // One table entry
   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [WORD_W-1:0] ctrl;
      logic [WORD_W-1:0] status;
   } entry_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_RD,
      ST_LOAD_CHK,
      ST_DIV_STEP,
      ST_DIV_LEVEL,
      ST_INDEX,
      ST_REQ_RD,
      ST_REQ_CHK,
      ST_CONF_RD,
      ST_CONF_CHK,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pstate_table_selector_core.sv =====
// ----------------------------------------------------------------------------
// pstate_table_selector_core - performance-state table selector
// Keeps a table of performance states, maps a 0..100 level to a table index
// and checks status read-back against the pending state.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Moves
//  req_     in         req_valid/stall    one action with its operand fields
//  rsp_     out        rsp_valid/stall    one result beat per action
//  csr_     in         csr_write          perf_limit (0), control_ready (1)
//
//  A level request makes two 7-step passes through the shared restoring
//  divider: 100/len, then level/step.
//  req_stall is high from acceptance until the result moves into the
//  output register; a result waiting on rsp_stall does not stop the next
//  request being taken, only its hand-over.
//  Reset is synchronous and active high; table contents are not cleared.
//
`timescale 1ns / 1ps
`default_nettype none

module pstate_table_selector_core
   import pts_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   localparam int IDX_W = $clog2(TABLE_DEPTH),
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [ACTION_W-1:0] req_action,
   input  wire logic [FREQ_W-1:0]   req_entry_freq,
   input  wire logic [WORD_W-1:0]   req_entry_ctrl,
   input  wire logic [WORD_W-1:0]   req_entry_status,
   input  wire logic [LEVEL_W-1:0]  req_level,
   input  wire logic [WORD_W-1:0]   req_read_status,
   // result channel
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [CODE_W-1:0]   rsp_code,
   output      logic [WORD_W-1:0]   rsp_write_ctrl,
   output      logic [IDX_W-1:0]    rsp_target_index,
   output      logic [CNT_W-1:0]    rsp_table_count,
   output      logic [FREQ_W-1:0]   rsp_current_freq,
   output      logic [LEVEL_W-1:0]  rsp_current_level,
   // register port
   input  wire logic                csr_write,
   input  wire logic [CSR_IX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]    csr_wdata
);

   // signed width for the index arithmetic
   localparam int IW = ((CNT_W > DIV_W) ? CNT_W : DIV_W) + 2;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

   function automatic logic freq_is_bad(input logic [FREQ_W-1:0] f);
      return (f == '0) || (f == FREQ_HEX_ONES) || (f == FREQ_HEX_NINES) ||
             (f == FREQ_DEC_NINES);
   endfunction

   // sequencer and control state
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic [LEVEL_W-1:0]   pend_lvl_ff, pend_lvl_in;
   logic [LEVEL_W-1:0]   conf_lvl_ff, conf_lvl_in;
   logic [FREQ_W-1:0]    conf_freq_ff, conf_freq_in;
   logic [LIMIT_W-1:0]   perf_limit_ff, perf_limit_in;
   logic                 ctrl_ready_ff, ctrl_ready_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // latched request beat
   logic [LEVEL_W-1:0]   lvl_ff, lvl_in;
   logic [FREQ_W-1:0]    in_freq_ff, in_freq_in;
   logic [WORD_W-1:0]    in_ctrl_ff, in_ctrl_in;
   logic [WORD_W-1:0]    in_stat_ff, in_stat_in;
   logic [WORD_W-1:0]    rd_stat_ff, rd_stat_in;

   // shared divider
   logic [DIV_W-1:0]     len_ff, len_in;
   logic [DIV_W-1:0]     div_rem_ff, div_rem_in;
   logic [DIV_W-1:0]     div_quo_ff, div_quo_in;
   logic [DIV_W-1:0]     div_sor_ff, div_sor_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [DIV_W:0]       div_trial, div_diff;
   logic                 div_take;
   logic [DIV_W-1:0]     rem_step, quo_step;

   // index selection
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic signed [IW-1:0] idx_a, idx_b, idx_max;

   // result holding and output registers
   logic [CODE_W-1:0]    res_code_ff, res_code_in;
   logic [WORD_W-1:0]    res_wctrl_ff, res_wctrl_in;
   logic [IDX_W-1:0]     res_tidx_ff, res_tidx_in;
   logic [CODE_W-1:0]    rsp_code_ff, rsp_code_in;
   logic [WORD_W-1:0]    rsp_wctrl_ff, rsp_wctrl_in;
   logic [IDX_W-1:0]     rsp_tidx_ff, rsp_tidx_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic [FREQ_W-1:0]    rsp_freq_ff, rsp_freq_in;
   logic [LEVEL_W-1:0]   rsp_lvl_ff, rsp_lvl_in;

   // table memory
   entry_type            table_mem [TABLE_DEPTH];
   entry_type            rd_data_ff;
   entry_type            mem_wd;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_ra;
   logic [CNT_W-1:0]     cnt_dec;

   logic                 req_accept;
   logic                 out_free;
   logic                 req_reject;
   logic                 conf_stale;

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_reject = (req_level > LEVEL_MAX) || !ctrl_ready_ff || (count_ff == '0);
   assign conf_stale = CNT_W'(pend_idx_ff) >= count_ff;

   // one restoring step of the shared divider
   always_comb begin
      div_trial = {div_rem_ff, div_quo_ff[DIV_W-1]};
      div_diff  = div_trial - {1'b0, div_sor_ff};
      div_take  = !div_diff[DIV_W];
      rem_step  = div_take ? div_diff[DIV_W-1:0] : div_trial[DIV_W-1:0];
      quo_step  = {div_quo_ff[DIV_W-2:0], div_take};
   end

   // idx = (len-1) - level/step, floored at 0, shifted by the limit, clamped
   always_comb begin
      idx_max = $signed(IW'(count_ff) - IW'(1));
      idx_a   = $signed(IW'(len_ff) - IW'(1) - IW'(div_quo_ff));
      if (idx_a < 0) begin
         idx_a = '0;
      end
      idx_b = idx_a;
      if (perf_limit_ff != '0) begin
         idx_b = $signed(IW'(idx_a) + IW'(count_ff) - IW'(perf_limit_ff));
      end
      if (idx_b < 0) begin
         idx_b = '0;
      end
      if (idx_b > idx_max) begin
         idx_b = idx_max;
      end
      idx_in = idx_b[IDX_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_action)
                  ACT_CLEAR:   state_in = ST_OUT;
                  ACT_LOAD:    state_in = ST_LOAD_RD;
                  ACT_REQUEST: state_in = req_reject ? ST_OUT : ST_DIV_STEP;
                  default:     state_in = (!ctrl_ready_ff || conf_stale) ? ST_OUT
                                                                         : ST_CONF_RD;
               endcase
            end
         end
         ST_LOAD_RD:   state_in = ST_LOAD_CHK;
         ST_LOAD_CHK:  state_in = ST_OUT;
         ST_DIV_STEP: begin
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_DIV_LEVEL;
            end
         end
         ST_DIV_LEVEL: begin
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_INDEX;
            end
         end
         ST_INDEX:     state_in = ST_REQ_RD;
         ST_REQ_RD:    state_in = ST_REQ_CHK;
         ST_REQ_CHK:   state_in = ST_OUT;
         ST_CONF_RD:   state_in = ST_CONF_CHK;
         ST_CONF_CHK:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // memory read address
   always_comb begin
      cnt_dec = count_ff - CNT_W'(1);
      case (state_ff)
         ST_LOAD_RD: mem_ra = cnt_dec[IDX_W-1:0];
         ST_CONF_RD: mem_ra = pend_idx_ff;
         default:    mem_ra = idx_ff;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in      = count_ff;
      pend_idx_in   = pend_idx_ff;
      pend_lvl_in   = pend_lvl_ff;
      conf_lvl_in   = conf_lvl_ff;
      conf_freq_in  = conf_freq_ff;
      perf_limit_in = perf_limit_ff;
      ctrl_ready_in = ctrl_ready_ff;
      rsp_valid_in  = rsp_valid_ff;
      lvl_in        = lvl_ff;
      in_freq_in    = in_freq_ff;
      in_ctrl_in    = in_ctrl_ff;
      in_stat_in    = in_stat_ff;
      rd_stat_in    = rd_stat_ff;
      len_in        = len_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      div_sor_in    = div_sor_ff;
      div_cnt_in    = div_cnt_ff;
      res_code_in   = res_code_ff;
      res_wctrl_in  = res_wctrl_ff;
      res_tidx_in   = res_tidx_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_wctrl_in  = rsp_wctrl_ff;
      rsp_tidx_in   = rsp_tidx_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_freq_in   = rsp_freq_ff;
      rsp_lvl_in    = rsp_lvl_ff;
      mem_we        = 1'b0;
      mem_wd        = '{freq: in_freq_ff, ctrl: in_ctrl_ff, status: in_stat_ff};

      // register writes
      if (csr_write) begin
         case (csr_index)
            CSR_PERF_LIMIT:    perf_limit_in = csr_wdata[LIMIT_W-1:0];
            CSR_CONTROL_READY: ctrl_ready_in = csr_wdata[0];
            default:           ;
         endcase
      end

      // output beat taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               lvl_in       = req_level;
               in_freq_in   = req_entry_freq;
               in_ctrl_in   = req_entry_ctrl;
               in_stat_in   = req_entry_status;
               rd_stat_in   = req_read_status;
               res_code_in  = RC_KEPT;
               res_wctrl_in = '0;
               res_tidx_in  = '0;
               // prime the divider with 100 / len
               len_in       = (perf_limit_ff != '0) ? DIV_W'(perf_limit_ff)
                                                    : DIV_W'(count_ff);
               div_rem_in   = '0;
               div_quo_in   = FULL_SCALE;
               div_sor_in   = len_in;
               div_cnt_in   = '0;
               case (req_action)
                  ACT_CLEAR: count_in = '0;
                  ACT_LOAD:  ;
                  ACT_REQUEST: begin
                     if (req_level > LEVEL_MAX) begin
                        res_code_in = RC_BAD_LEVEL;
                     end else if (!ctrl_ready_ff || (count_ff == '0)) begin
                        res_code_in = RC_UNAVAILABLE;
                     end
                  end
                  default: begin
                     if (!ctrl_ready_ff) begin
                        res_code_in = RC_UNAVAILABLE;
                     end else begin
                        res_tidx_in = pend_idx_ff;
                        if (conf_stale) begin
                           res_code_in = RC_FAILED;
                        end
                     end
                  end
               endcase
            end
         end

         // repeat check ahead of the bad-value check
         ST_LOAD_CHK: begin
            if ((count_ff != '0) && (rd_data_ff.freq == in_freq_ff)) begin
               res_code_in = RC_REPEAT;
            end else if (freq_is_bad(in_freq_ff) ||
                         (count_ff == CNT_W'(TABLE_DEPTH))) begin
               res_code_in = RC_BAD_FREQ;
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end

         // step = 100 / len, then reload for level / step
         ST_DIV_STEP: begin
            div_rem_in = rem_step;
            div_quo_in = quo_step;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_LAST) begin
               div_rem_in = '0;
               div_quo_in = DIV_W'(lvl_ff);
               div_sor_in = (quo_step == '0) ? DIV_W'(1) : quo_step;
               div_cnt_in = '0;
            end
         end

         ST_DIV_LEVEL: begin
            div_rem_in = rem_step;
            div_quo_in = quo_step;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         end

         ST_REQ_CHK: begin
            res_tidx_in = idx_ff;
            if (rd_stat_ff == rd_data_ff.status) begin
               res_code_in = RC_ALREADY;
            end else begin
               res_code_in  = RC_WRITE;
               res_wctrl_in = rd_data_ff.ctrl;
               pend_idx_in  = idx_ff;
               pend_lvl_in  = lvl_ff;
            end
         end

         ST_CONF_CHK: begin
            if (rd_stat_ff == rd_data_ff.status) begin
               res_code_in  = RC_OK;
               conf_freq_in = rd_data_ff.freq;
               conf_lvl_in  = pend_lvl_ff;
            end else begin
               res_code_in = RC_FAILED;
            end
         end

         // hand the result to the output register once it is free
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = res_code_ff;
               rsp_wctrl_in = res_wctrl_ff;
               rsp_tidx_in  = res_tidx_ff;
               rsp_count_in = count_ff;
               rsp_freq_in  = conf_freq_ff;
               rsp_lvl_in   = conf_lvl_ff;
            end
         end

         default: ;
      endcase
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[count_ff[IDX_W-1:0]] <= mem_wd;
      end
      rd_data_ff <= table_mem[mem_ra];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_idx_ff   <= '0;
         pend_lvl_ff   <= '0;
         conf_lvl_ff   <= '0;
         conf_freq_ff  <= '0;
         perf_limit_ff <= '0;
         ctrl_ready_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_idx_ff   <= pend_idx_in;
         pend_lvl_ff   <= pend_lvl_in;
         conf_lvl_ff   <= conf_lvl_in;
         conf_freq_ff  <= conf_freq_in;
         perf_limit_ff <= perf_limit_in;
         ctrl_ready_ff <= ctrl_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lvl_ff       <= lvl_in;
      in_freq_ff   <= in_freq_in;
      in_ctrl_ff   <= in_ctrl_in;
      in_stat_ff   <= in_stat_in;
      rd_stat_ff   <= rd_stat_in;
      len_ff       <= len_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_sor_ff   <= div_sor_in;
      div_cnt_ff   <= div_cnt_in;
      idx_ff       <= (state_ff == ST_INDEX) ? idx_in : idx_ff;
      res_code_ff  <= res_code_in;
      res_wctrl_ff <= res_wctrl_in;
      res_tidx_ff  <= res_tidx_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_wctrl_ff <= rsp_wctrl_in;
      rsp_tidx_ff  <= rsp_tidx_in;
      rsp_count_ff <= rsp_count_in;
      rsp_freq_ff  <= rsp_freq_in;
      rsp_lvl_ff   <= rsp_lvl_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_code          = rsp_code_ff;
   assign rsp_write_ctrl    = rsp_wctrl_ff;
   assign rsp_target_index  = rsp_tidx_ff;
   assign rsp_table_count   = rsp_count_ff;
   assign rsp_current_freq  = rsp_freq_ff;
   assign rsp_current_level = rsp_lvl_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pts_checker.sv =====
// ----------------------------------------------------------------------------
// pts_checker - port-level checks for the performance-state table selector
// Watches the top-level ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pts_checker
   import pts_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   localparam int IDX_W = $clog2(TABLE_DEPTH),
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [CODE_W-1:0]   rsp_code,
   input wire logic [WORD_W-1:0]   rsp_write_ctrl,
   input wire logic [IDX_W-1:0]    rsp_target_index,
   input wire logic [CNT_W-1:0]    rsp_table_count
);

   // a stalled result beat stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code) &&
                                 $stable(rsp_write_ctrl))
      else $error("result beat changed while stalled");

   // one item at a time: busy right after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one still in work");

   // selected index always lies inside the kept table
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_code == RC_WRITE || rsp_code == RC_ALREADY) |->
         CNT_W'(rsp_target_index) < rsp_table_count)
      else $error("target index beyond table count");

   // control word only shown with a write
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code != RC_WRITE |-> rsp_write_ctrl == '0)
      else $error("control word set on a non-write result");

   // table never reports more entries than it holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_table_count <= CNT_W'(TABLE_DEPTH))
      else $error("table count beyond depth");

endmodule

bind pstate_table_selector_core pts_checker #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_pts_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_code         (rsp_code),
   .rsp_write_ctrl   (rsp_write_ctrl),
   .rsp_target_index (rsp_target_index),
   .rsp_table_count  (rsp_table_count)
);

`default_nettype wire
